// ===== hdl/imk_pkg.sv =====
// Package for the iambic keyer: field widths, paddle codes, register indexes,
// register reset values and the structs shared by the top level and the core.
// No dependencies.
`timescale 1ns / 1ps

package imk_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned DIT_W   = 8;
	localparam int unsigned COUNT_W = 10;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned DATA_W  = 10;

	typedef enum logic [1:0] {
		EL_NONE = 2'd0,
		EL_DOT  = 2'd1,
		EL_DASH = 2'd2,
		EL_BOTH = 2'd3
	} el_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_BOTH_THR = 3'd0,
		REG_DOT_THR  = 3'd1,
		REG_DASH_THR = 3'd2,
		REG_DIT      = 3'd3,
		REG_MODE_B   = 3'd4
	} reg_idx_t;

	localparam logic [LEVEL_W-1:0] BOTH_THR_RST = 10'd300;
	localparam logic [LEVEL_W-1:0] DOT_THR_RST  = 10'd600;
	localparam logic [LEVEL_W-1:0] DASH_THR_RST = 10'd900;
	localparam logic [DIT_W-1:0]   DIT_RST      = 8'd10;
	localparam logic               MODE_B_RST   = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] both_thr;
		logic [LEVEL_W-1:0] dot_thr;
		logic [LEVEL_W-1:0] dash_thr;
		logic [DIT_W-1:0]   dit_ticks;
		logic               mode_b;
	} cfg_t;

	typedef struct packed {
		logic tone_on;
		logic tx_start;
		logic hang_load;
	} result_t;

	function automatic el_t opposite(el_t el);
		return (el == EL_DOT) ? EL_DASH : EL_DOT;
	endfunction

endpackage

// ===== hdl/imk_if.sv =====
// Channel interfaces for the keyer: paddle samples in, key results out,
// register writes. Depends on imk_pkg.
`timescale 1ns / 1ps

interface imk_in_if;
	logic                        valid;
	logic                        ready;
	logic [imk_pkg::LEVEL_W-1:0] paddle_level;
	logic                        tx_active;

	modport source (output valid, output paddle_level, output tx_active, input ready);
	modport sink (input valid, input paddle_level, input tx_active, output ready);
endinterface

interface imk_out_if;
	logic valid;
	logic ready;
	logic tone_on;
	logic tx_start;
	logic hang_load;

	modport source (output valid, output tone_on, output tx_start, output hang_load,
		input ready);
	modport sink (input valid, input tone_on, input tx_start, input hang_load,
		output ready);
endinterface

interface imk_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [imk_pkg::INDEX_W-1:0] index;
	logic [imk_pkg::DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/imk_core.sv =====
// Keyer state and per-tick step: paddle classification, element start,
// element and space timing, mode B memory. Depends on imk_pkg.
`timescale 1ns / 1ps

module imk_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [imk_pkg::LEVEL_W-1:0] level,
	input  logic                        tx,
	input  imk_pkg::cfg_t               cfg,
	output imk_pkg::result_t            res
);
	import imk_pkg::*;

	logic [COUNT_W-1:0] tc_q;
	logic               in_el_q;
	logic               alt_q;
	el_t                last_q;

	logic [COUNT_W-1:0] tc_n;
	logic               in_el_n;
	logic               alt_n;
	el_t                last_n;
	el_t                paddle;
	el_t                nxt;
	logic [DIT_W-1:0]   dit_len;
	logic [COUNT_W-1:0] dit10;
	logic [COUNT_W-1:0] dash10;

	always_comb begin
		if (level < cfg.dot_thr) begin
			paddle = (level < cfg.both_thr) ? EL_BOTH : EL_DOT;
		end else begin
			paddle = (level < cfg.dash_thr) ? EL_DASH : EL_NONE;
		end
	end

	assign dit_len = (cfg.dit_ticks == '0) ? DIT_W'(1) : cfg.dit_ticks;
	assign dit10   = COUNT_W'(dit_len);
	assign dash10  = dit10 + {dit10[COUNT_W-2:0], 1'b0};

	always_comb begin
		tc_n          = tc_q;
		in_el_n       = in_el_q;
		alt_n         = alt_q;
		last_n        = last_q;
		nxt           = EL_NONE;
		res.tx_start  = 1'b0;
		res.hang_load = 1'b0;
		if (tc_q == '0) begin
			if (alt_q) begin
				alt_n = 1'b0;
				nxt   = opposite(last_q);
			end else if (paddle == EL_BOTH) begin
				nxt = opposite(last_q);
			end else begin
				nxt = paddle;
			end
			last_n = nxt;
			if (nxt != EL_NONE) begin
				tc_n         = ((nxt == EL_DASH) ? dash10 : dit10) + COUNT_W'(1);
				in_el_n      = 1'b1;
				res.tx_start = !tx;
			end
		end
		if (tc_n != '0) begin
			if ((last_n | paddle) == EL_BOTH) begin
				alt_n = cfg.mode_b;
			end
			tc_n = tc_n - COUNT_W'(1);
			if (tc_n == '0) begin
				if (in_el_n) begin
					in_el_n = 1'b0;
					tc_n    = dit10 - COUNT_W'(1);
					if (tc_n == '0) begin
						res.hang_load = 1'b1;
					end
				end else begin
					res.hang_load = 1'b1;
				end
			end
		end
		res.tone_on = in_el_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q    <= '0;
			in_el_q <= 1'b0;
			alt_q   <= 1'b0;
			last_q  <= EL_NONE;
		end else if (advance) begin
			tc_q    <= tc_n;
			in_el_q <= in_el_n;
			alt_q   <= alt_n;
			last_q  <= last_n;
		end
	end

endmodule

// ===== hdl/iambic_morse_keyer_top.sv =====
// Top level of the iambic keyer: register file, input stage, output stage.
// Depends on imk_pkg, imk_if and imk_core.
//
//   channel   modport   beat carries
//   paddle    sink      paddle_level, tx_active (one tick)
//   result    source    tone_on, tx_start, hang_load (one per tick)
//   cfg       sink      index, data (register write, always ready)
//
// One tick per cycle sustained while result.ready stays high; a taken tick waits in the input
// stage, and its result is offered once it moves into the result register.
// The input stage and the result register each hold one beat, so a stalled result
// still lets one more tick in. The keyer state advances when a tick moves from the
// input stage into the result register. Reset clears state and loads register
// defaults.
`timescale 1ns / 1ps

module iambic_morse_keyer_top (
	input logic clk,
	input logic arst_n,
	imk_in_if.sink    paddle,
	imk_out_if.source result,
	imk_cfg_if.sink   cfg
);
	import imk_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic               tx_s1;
	logic               valid_s2;
	result_t            res_s2;
	result_t            res_n;
	logic               advance;

	assign cfg.ready    = 1'b1;
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign paddle.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.both_thr  <= BOTH_THR_RST;
			cfg_q.dot_thr   <= DOT_THR_RST;
			cfg_q.dash_thr  <= DASH_THR_RST;
			cfg_q.dit_ticks <= DIT_RST;
			cfg_q.mode_b    <= MODE_B_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BOTH_THR: cfg_q.both_thr  <= cfg.data[LEVEL_W-1:0];
				REG_DOT_THR:  cfg_q.dot_thr   <= cfg.data[LEVEL_W-1:0];
				REG_DASH_THR: cfg_q.dash_thr  <= cfg.data[LEVEL_W-1:0];
				REG_DIT:      cfg_q.dit_ticks <= cfg.data[DIT_W-1:0];
				REG_MODE_B:   cfg_q.mode_b    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (paddle.ready) begin
				valid_s1 <= paddle.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (paddle.valid && paddle.ready) begin
			level_s1 <= paddle.paddle_level;
			tx_s1    <= paddle.tx_active;
		end
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	imk_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (level_s1),
		.tx      (tx_s1),
		.cfg     (cfg_q),
		.res     (res_n)
	);

	assign result.valid     = valid_s2;
	assign result.tone_on   = res_s2.tone_on;
	assign result.tx_start  = res_s2.tx_start;
	assign result.hang_load = res_s2.hang_load;

endmodule

// ===== hdl/imk_checker.sv =====
// Port-level checks for the iambic keyer and the bind that attaches them.
// Depends on iambic_morse_keyer_top and imk_if.
`timescale 1ns / 1ps

module imk_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic tone_on,
	input logic tx_start,
	input logic hang_load
);
	logic prev_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_start_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			prev_start_q <= tx_start;
		end
	end

	a_start_keys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_start |-> tone_on)
		else $error("tx_start without tone");

	a_hang_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hang_load |-> !tone_on && !tx_start)
		else $error("hang_load while keyed or starting");

	a_no_double_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && tx_start |-> !prev_start_q)
		else $error("tx_start on two beats in a row");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tone_on) && $stable(tx_start)
			&& $stable(hang_load))
		else $error("stalled result changed");

endmodule

bind iambic_morse_keyer_top imk_checker u_imk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.tone_on   (result.tone_on),
	.tx_start  (result.tx_start),
	.hang_load (result.hang_load)
);

// ===== tb/keyer_checker.sv =====
// Scoreboard for the iambic keyer: watches the paddle, register and result channels,
// predicts one result beat per tick and compares it field by field.
// Depends on imk_pkg and imk_if.
`timescale 1ns / 1ps

module keyer_checker import imk_pkg::*; (
	input logic clk,
	input logic arst_n,
	imk_in_if   paddle,
	imk_cfg_if  cfg,
	imk_out_if  result,
	output int  fails,
	output int  outstanding,
	output int  checked,
	output int  starts,
	output int  hangs
);

	cfg_t               regs;
	logic [COUNT_W-1:0] remaining;
	logic               keying;
	logic               alt_mem;
	el_t                prev_el;
	result_t            tick_results_q[$];
	int                 n_fail = 0;
	int                 n_checked = 0;
	int                 n_start = 0;
	int                 n_hang = 0;

	function automatic el_t sort_paddle(logic [LEVEL_W-1:0] lvl);
		if (lvl < regs.dot_thr) begin
			return (lvl < regs.both_thr) ? EL_BOTH : EL_DOT;
		end
		return (lvl < regs.dash_thr) ? EL_DASH : EL_NONE;
	endfunction

	function automatic result_t keyer_tick(logic [LEVEL_W-1:0] lvl, logic tx);
		el_t                pad;
		el_t                nxt;
		el_t                flip;
		logic [COUNT_W-1:0] dlen;
		result_t            r;
		pad = sort_paddle(lvl);
		flip = (prev_el == EL_DOT) ? EL_DASH : EL_DOT;
		dlen = (regs.dit_ticks == '0) ? COUNT_W'(1) : COUNT_W'(regs.dit_ticks);
		r = '0;
		if (remaining == '0) begin
			if (alt_mem) begin
				alt_mem = 1'b0;
				nxt = flip;
			end else if (pad == EL_BOTH) begin
				nxt = flip;
			end else begin
				nxt = pad;
			end
			prev_el = nxt;
			if (nxt != EL_NONE) begin
				remaining = (nxt == EL_DASH) ? COUNT_W'(dlen * 3 + 1) : COUNT_W'(dlen + 1);
				keying = 1'b1;
				r.tx_start = !tx;
			end
		end
		if (remaining != '0) begin
			if ((prev_el | pad) == EL_BOTH) begin
				alt_mem = regs.mode_b;
			end
			remaining = remaining - 1'b1;
			if (remaining == '0) begin
				if (keying) begin
					keying = 1'b0;
					remaining = dlen - 1'b1;
					if (remaining == '0) begin
						r.hang_load = 1'b1;
					end
				end else begin
					r.hang_load = 1'b1;
				end
			end
		end
		r.tone_on = keying;
		return r;
	endfunction

	function automatic void check_field(string name, logic want, logic got);
		if (want !== got) begin
			n_fail++;
			$display("%0t: %s expected %0b, got %0b", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs = '{BOTH_THR_RST, DOT_THR_RST, DASH_THR_RST, DIT_RST, MODE_B_RST};
			remaining = '0;
			keying = 1'b0;
			alt_mem = 1'b0;
			prev_el = EL_NONE;
			tick_results_q.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (tick_results_q.size() == 0) begin
					n_fail++;
					$display("%0t: result beat with no tick pending (%0b %0b %0b)", $time,
						result.tone_on, result.tx_start, result.hang_load);
				end else begin
					want = tick_results_q.pop_front();
					n_checked++;
					n_start += want.tx_start;
					n_hang += want.hang_load;
					check_field("tone_on", want.tone_on, result.tone_on);
					check_field("tx_start", want.tx_start, result.tx_start);
					check_field("hang_load", want.hang_load, result.hang_load);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_BOTH_THR: regs.both_thr = cfg.data;
					REG_DOT_THR:  regs.dot_thr = cfg.data;
					REG_DASH_THR: regs.dash_thr = cfg.data;
					REG_DIT:      regs.dit_ticks = cfg.data[DIT_W-1:0];
					REG_MODE_B:   regs.mode_b = cfg.data[0];
					default: ;
				endcase
			end
			if (paddle.valid && paddle.ready) begin
				tick_results_q.push_back(keyer_tick(paddle.paddle_level, paddle.tx_active));
			end
		end
		fails <= n_fail;
		outstanding <= tick_results_q.size();
		checked <= n_checked;
		starts <= n_start;
		hangs <= n_hang;
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the keyer testbench: clock, reset, paddle tick and register stimulus, result
// back-pressure and the verdict. Depends on imk_pkg, imk_if, keyer_checker and the keyer.
`timescale 1ns / 1ps

module testbench;
	import imk_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   fails, outstanding, checked, starts, hangs;
	bit   tx_idle = 1'b1;
	bit   rx_idle = 1'b1;
	bit   long_hold = 1'b0;
	int   thr_both = BOTH_THR_RST;
	int   thr_dot = DOT_THR_RST;
	int   thr_dash = DASH_THR_RST;
	int   dit_set = DIT_RST;

	imk_in_if  paddle();
	imk_out_if result();
	imk_cfg_if cfg();

	iambic_morse_keyer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.paddle (paddle),
		.result (result),
		.cfg    (cfg)
	);

	keyer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.paddle      (paddle),
		.cfg         (cfg),
		.result      (result),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked),
		.starts      (starts),
		.hangs       (hangs)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Timeout after %0d cycles, %0d ticks still pending", cycles, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		result.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic logic [LEVEL_W-1:0] pick_level(el_t want);
		int lo, hi;
		case (want)
			EL_BOTH: begin
				lo = 0;
				hi = ((thr_both < thr_dot) ? thr_both : thr_dot) - 1;
			end
			EL_DOT: begin
				lo = thr_both;
				hi = thr_dot - 1;
			end
			EL_DASH: begin
				lo = thr_dot;
				hi = thr_dash - 1;
			end
			default: begin
				lo = (thr_dot > thr_dash) ? thr_dot : thr_dash;
				hi = 1023;
			end
		endcase
		if (lo > hi) begin
			return LEVEL_W'($urandom_range(0, 1023));
		end
		return LEVEL_W'($urandom_range(lo, hi));
	endfunction

	task automatic send_tick(input logic [LEVEL_W-1:0] lvl, input logic tx);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			paddle.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		paddle.valid <= 1'b1;
		paddle.paddle_level <= lvl;
		paddle.tx_active <= tx;
		do @(posedge clk); while (!paddle.ready);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= DATA_W'(val);
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic apply_cfg(input int both, input int dot, input int dash, input int dit,
		input int mode);
		write_reg(REG_BOTH_THR, both);
		write_reg(REG_DOT_THR, dot);
		write_reg(REG_DASH_THR, dash);
		write_reg(REG_DIT, dit);
		write_reg(REG_MODE_B, mode);
		cfg.valid <= 1'b0;
		thr_both = both;
		thr_dot = dot;
		thr_dash = dash;
		dit_set = dit;
	endtask

	task automatic drain;
		paddle.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// hold one paddle position per run, with some runs of raw noise
	task automatic run_phase(input int items);
		int   left, n, d, run_max;
		el_t  want;
		logic tx;
		bit   noisy;
		d = (dit_set == 0) ? 1 : dit_set;
		run_max = (3 * d + 6 > 40) ? 40 : 3 * d + 6;
		left = items;
		while (left > 0) begin
			noisy = ($urandom_range(0, 4) == 0);
			want = el_t'($urandom_range(0, 3));
			tx = 1'($urandom_range(0, 1));
			n = $urandom_range(1, run_max);
			repeat (n) begin
				if (noisy) begin
					send_tick(LEVEL_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
				end else begin
					send_tick(pick_level(want), tx);
				end
			end
			left -= n;
		end
	endtask

	initial begin
		int dir_lv [24] = '{0, 0, 299, 300, 599, 600, 899, 900, 1023, 1023, 512, 255,
			768, 1, 1022, 0, 1023, 1023, 1023, 1023, 700, 100, 1023, 1023};
		int t1, t2, t3;
		paddle.valid = 1'b0;
		paddle.paddle_level = '0;
		paddle.tx_active = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: ;
				1: apply_cfg(300, 600, 900, 1, 0);
				2: apply_cfg(1023, 1023, 1023, 255, 1);
				3: apply_cfg(200, 500, 800, 0, 1);
				4: apply_cfg(700, 400, 1000, 2, 1);
				5: apply_cfg(0, 0, 0, 3, 0);
				default: begin
					t1 = $urandom_range(0, 400);
					t2 = t1 + $urandom_range(0, 400);
					t3 = t2 + $urandom_range(0, 1023 - t2);
					apply_cfg(t1, t2, t3, $urandom_range(1, 5), $urandom_range(0, 1));
				end
			endcase
			if (p == 0) begin
				// squeeze straight out of reset, then walk the threshold edges
				for (int i = 0; i < 24; i++) begin
					send_tick(LEVEL_W'(dir_lv[i]), (i % 3) == 1);
				end
			end
			if (p == 7) begin
				long_hold = 1'b1;
			end
			if (p == 8) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			run_phase((p == 5) ? 60 : 210);
			drain;
		end
		$display("Checked %0d tick results over 9 register settings (dit 0 to 255, modes A and B)",
			checked);
		$display("Seen %0d transmit starts and %0d hang reloads", starts, hangs);
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/imk_pkg.sv
hdl/imk_if.sv
hdl/imk_core.sv
hdl/iambic_morse_keyer_top.sv
hdl/imk_checker.sv
tb/keyer_checker.sv
tb/testbench.sv
